@@ hdl/tvn_pkg.sv @@
// tvn_pkg: shared constants and register codes for the tileable value noise block
// no dependencies; used by tvn_octave, tvn_norm, tileable_value_noise_fbm, tvn_checker and the test
`timescale 1ns / 1ps
package tvn_pkg;

  // default parameter values
  localparam int MAX_OCTAVES_DEF = 8;
  localparam int COORD_BITS_DEF  = 12;

  // lattice hash constants
  localparam logic [31:0] HASH_KX   = 32'd374761393;
  localparam logic [31:0] HASH_KY   = 32'd668265263;
  localparam logic [31:0] MIX_M1    = 32'h7feb352d;
  localparam logic [31:0] MIX_M2    = 32'h846ca68b;
  localparam logic [31:0] OCT_STEP  = 32'd7919;

  // smoothstep constant 3 * 2^16
  localparam logic [17:0] SMOOTH_K  = 18'd196608;

  // quotient bits of the normalising divider
  localparam int QBITS = 17;

  // configuration register codes
  typedef enum logic [1:0] {
    REG_TILE_LOG2    = 2'd0,
    REG_BASE_PERIOD  = 2'd1,
    REG_OCTAVE_COUNT = 2'd2,
    REG_NOISE_SEED   = 2'd3
  } reg_index_t;

  // reset values of the registers
  localparam logic [3:0]  TILE_LOG2_RST    = 4'd8;
  localparam logic [6:0]  BASE_PERIOD_RST  = 7'd4;
  localparam logic [3:0]  OCTAVE_COUNT_RST = 4'd3;
  localparam logic [31:0] NOISE_SEED_RST   = 32'd40503;

endpackage

@@ hdl/tileable_value_noise_fbm.sv @@
// tileable_value_noise_fbm: top level, configuration registers, octave lanes, normaliser
// depends on tvn_pkg, tvn_octave and tvn_norm
`timescale 1ns / 1ps
// Takes one pixel per clock cycle and returns its fractal noise level through
// the input register, ten stages of octave lane, a sum stage, seventeen
// divider stages and an output register. busy is low except in reset, so
// start may be held high for every cycle of a raster scan. done strobes for
// one cycle with noise_level; the receiver cannot stall, so results must be
// taken as they come. All octaves run as parallel lanes; write configuration
// only once the last result of earlier transactions has come out.
module tileable_value_noise_fbm #(
  parameter int MAX_OCTAVES = tvn_pkg::MAX_OCTAVES_DEF,
  parameter int COORD_BITS  = tvn_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  output logic                  done,
  output logic [15:0]           noise_level,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  localparam int KW = $clog2(MAX_OCTAVES + 1);

  logic [3:0]  tile_log2;
  logic [6:0]  base_period;
  logic [3:0]  octave_count;
  logic [31:0] noise_seed;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_log2    <= tvn_pkg::TILE_LOG2_RST;
      base_period  <= tvn_pkg::BASE_PERIOD_RST;
      octave_count <= tvn_pkg::OCTAVE_COUNT_RST;
      noise_seed   <= tvn_pkg::NOISE_SEED_RST;
    end else if (cfg_we) begin
      case (tvn_pkg::reg_index_t'(cfg_index))
        tvn_pkg::REG_TILE_LOG2:    tile_log2    <= cfg_data[3:0];
        tvn_pkg::REG_BASE_PERIOD:  base_period  <= cfg_data[6:0];
        tvn_pkg::REG_OCTAVE_COUNT: octave_count <= cfg_data[3:0];
        tvn_pkg::REG_NOISE_SEED:   noise_seed   <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective octave count, clamped to 1..MAX_OCTAVES
  logic [4:0]    oc5;
  logic [KW-1:0] k_eff;
  always_comb begin
    oc5 = {1'b0, octave_count};
    if (oc5 == 5'd0) begin
      k_eff = KW'(1);
    end else if (oc5 > 5'(MAX_OCTAVES)) begin
      k_eff = KW'(MAX_OCTAVES);
    end else begin
      k_eff = KW'(oc5);
    end
  end

  assign busy = rst;

  // input register
  logic                  in_vld;
  logic [COORD_BITS-1:0] px, py;
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
  end
  always_ff @(posedge clk) begin
    px <= pixel_x;
    py <= pixel_y;
  end

  // octave lanes
  logic [15:0]            levels [MAX_OCTAVES];
  logic [MAX_OCTAVES-1:0] lane_vld;

  for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
    tvn_octave #(
      .COORD_BITS(COORD_BITS),
      .OCT       (o)
    ) u_oct (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (in_vld),
      .px         (px),
      .py         (py),
      .tile_log2  (tile_log2),
      .base_period(base_period),
      .noise_seed (noise_seed),
      .out_valid  (lane_vld[o]),
      .level      (levels[o])
    );
  end

  // octave sum and normalisation
  tvn_norm #(
    .MAX_OCTAVES(MAX_OCTAVES),
    .KW         (KW)
  ) u_norm (
    .clk      (clk),
    .rst      (rst),
    .in_valid (&lane_vld),
    .levels   (levels),
    .k        (k_eff),
    .out_valid(done),
    .result   (noise_level)
  );

endmodule

@@ hdl/tvn_octave.sv @@
// tvn_octave: one octave lane, lattice position, corner hashes, smoothstep and blend
// depends on tvn_pkg
`timescale 1ns / 1ps
module tvn_octave #(
  parameter int COORD_BITS = tvn_pkg::COORD_BITS_DEF,
  parameter int OCT        = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  input  logic [3:0]            tile_log2,
  input  logic [6:0]            base_period,
  input  logic [31:0]           noise_seed,
  output logic                  out_valid,
  output logic [15:0]           level
);

  localparam int PW  = 7 + OCT;
  localparam int RXW = COORD_BITS + PW;
  localparam int EW  = (RXW > 16) ? RXW : 16;
  localparam int LAT = 10;

  logic [LAT-1:0] vld;

  // lattice period, tile mask: user keeps them static while items in flight; not enforced
  logic [PW-1:0]         period;
  logic [15:0]           mask16;
  logic [31:0]           seed_o;
  logic [COORD_BITS-1:0] rx_in, ry_in;

  always_comb begin
    period = (base_period == 7'd0) ? (PW'(1) << OCT) : (PW'(base_period) << OCT);
    mask16 = 16'((17'd1 << tile_log2) - 17'd1);
    seed_o = noise_seed + 32'(32'(OCT) * tvn_pkg::OCT_STEP);
    rx_in  = px & mask16[COORD_BITS-1:0];
    ry_in  = py & mask16[COORD_BITS-1:0];
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[LAT-1];

  // stage 1: in-tile offset times period
  logic [RXW-1:0] rx, ry;
  always_ff @(posedge clk) begin
    rx <= RXW'(rx_in) * RXW'(period);
    ry <= RXW'(ry_in) * RXW'(period);
  end

  // stage 2: wrapped lattice indices and Q0.16 fractions
  logic [PW-1:0] x0, x1, y0, y1;
  logic [15:0]   fx, fy;
  logic [PW-1:0] x0_c, y0_c;
  always_comb begin
    x0_c = PW'(rx >> tile_log2);
    y0_c = PW'(ry >> tile_log2);
  end
  always_ff @(posedge clk) begin
    x0 <= x0_c;
    y0 <= y0_c;
    x1 <= (x0_c == period - PW'(1)) ? '0 : x0_c + PW'(1);
    y1 <= (y0_c == period - PW'(1)) ? '0 : y0_c + PW'(1);
    fx <= 16'((EW'(rx) & EW'(mask16)) << (5'd16 - {1'b0, tile_log2}));
    fy <= 16'((EW'(ry) & EW'(mask16)) << (5'd16 - {1'b0, tile_log2}));
  end

  // stage 3: index products and fraction squares
  logic [31:0] mx0, mx1, my0, my1, sqx, sqy;
  logic [15:0] fx3, fy3;
  always_ff @(posedge clk) begin
    mx0 <= 32'(32'(x0) * tvn_pkg::HASH_KX);
    mx1 <= 32'(32'(x1) * tvn_pkg::HASH_KX);
    my0 <= 32'(32'(y0) * tvn_pkg::HASH_KY);
    my1 <= 32'(32'(y1) * tvn_pkg::HASH_KY);
    sqx <= 32'(fx) * 32'(fx);
    sqy <= 32'(fy) * 32'(fy);
    fx3 <= fx;
    fy3 <= fy;
  end

  // stage 4: corner hash inputs with first xorshift, smoothstep product
  logic [31:0] hs [4];
  logic [31:0] hc [4];
  logic [49:0] px4, py4;
  always_comb begin
    hc[0] = mx0 + my0 + seed_o;
    hc[1] = mx1 + my0 + seed_o;
    hc[2] = mx0 + my1 + seed_o;
    hc[3] = mx1 + my1 + seed_o;
  end
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      hs[i] <= hc[i] ^ (hc[i] >> 16);
    end
    px4 <= 50'(sqx) * 50'(tvn_pkg::SMOOTH_K - {1'b0, fx3, 1'b0});
    py4 <= 50'(sqy) * 50'(tvn_pkg::SMOOTH_K - {1'b0, fy3, 1'b0});
  end

  // stage 5: first mix multiply, rounded smoothstep weights
  logic [31:0] m1 [4];
  logic [16:0] tx5, ty5;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      m1[i] <= 32'(hs[i] * tvn_pkg::MIX_M1);
    end
    tx5 <= 17'((px4 + 50'h80000000) >> 32);
    ty5 <= 17'((py4 + 50'h80000000) >> 32);
  end

  // stage 6: second mix multiply
  logic [31:0] m2 [4];
  logic [16:0] tx6, ty6;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      m2[i] <= 32'((m1[i] ^ (m1[i] >> 15)) * tvn_pkg::MIX_M2);
    end
    tx6 <= tx5;
    ty6 <= ty5;
  end

  // stage 7: final xorshift leaves the top half untouched, top half is the corner value
  logic [15:0] cv [4];
  logic [16:0] tx7, ty7;
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      cv[i] <= m2[i][31:16];
    end
    tx7 <= tx6;
    ty7 <= ty6;
  end

  // stage 8: blend along x
  logic signed [17:0] dab, dcd, txs;
  logic signed [35:0] top, bot;
  logic [16:0]        ty8;
  always_comb begin
    dab = $signed({2'b00, cv[1]}) - $signed({2'b00, cv[0]});
    dcd = $signed({2'b00, cv[3]}) - $signed({2'b00, cv[2]});
    txs = $signed({1'b0, tx7});
  end
  always_ff @(posedge clk) begin
    top <= $signed({4'b0000, cv[0], 16'h0000}) + dab * txs;
    bot <= $signed({4'b0000, cv[2], 16'h0000}) + dcd * txs;
    ty8 <= ty7;
  end

  // stage 9: blend along y
  logic signed [36:0] dtb;
  logic signed [17:0] tys;
  logic signed [54:0] v;
  always_comb begin
    dtb = 37'(bot) - 37'(top);
    tys = $signed({1'b0, ty8});
  end
  always_ff @(posedge clk) begin
    v <= 55'($signed({top, 16'h0000})) + dtb * tys;
  end

  // stage 10: clamp and round to Q0.16
  logic [54:0] vr;
  always_comb begin
    vr = $unsigned(v) + 55'h80000000;
  end
  always_ff @(posedge clk) begin
    level <= v[54] ? 16'h0000 : vr[47:32];
  end

endmodule

@@ hdl/tvn_norm.sv @@
// tvn_norm: weighted octave sum and pipelined rounding divide by 2^K - 1
// depends on tvn_pkg
`timescale 1ns / 1ps
module tvn_norm #(
  parameter int MAX_OCTAVES = tvn_pkg::MAX_OCTAVES_DEF,
  parameter int KW          = $clog2(MAX_OCTAVES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [15:0]   levels [MAX_OCTAVES],
  input  logic [KW-1:0] k,
  output logic          out_valid,
  output logic [15:0]   result
);

  localparam int SW = 16 + MAX_OCTAVES;
  localparam int NW = MAX_OCTAVES + 18;
  localparam int QB = tvn_pkg::QBITS;

  // divisor twice 2^K - 1
  logic [MAX_OCTAVES:0]   den;
  logic [MAX_OCTAVES+1:0] dsr;
  always_comb begin
    den = (MAX_OCTAVES + 1)'(((MAX_OCTAVES + 1)'(1) << k) - (MAX_OCTAVES + 1)'(1));
    dsr = {den, 1'b0};
  end

  // weighted sum, numerator 2S + den
  logic [SW-1:0] acc;
  always_comb begin
    acc = '0;
    for (int o = 0; o < MAX_OCTAVES; o++) begin
      if (o < int'(k)) begin
        acc = acc + (SW'(levels[o]) << (int'(k) - 1 - o));
      end
    end
  end

  logic [NW-1:0] rem [QB+1];
  logic [QB-1:0] quo [QB+1];
  logic [QB:0]   dv;

  always_ff @(posedge clk) begin
    rem[0] <= NW'({acc, 1'b0}) + NW'(den);
    quo[0] <= '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else begin
      dv[0] <= in_valid;
    end
  end

  // restoring divider, one quotient bit per stage
  for (genvar g = 0; g < QB; g++) begin : g_div
    localparam int BIT = QB - 1 - g;
    logic [NW-1:0] thr;
    logic          hit;
    always_comb begin
      thr = NW'(dsr) << BIT;
      hit = (rem[g] >= thr);
    end
    always_ff @(posedge clk) begin
      rem[g+1] <= hit ? rem[g] - thr : rem[g];
      quo[g+1] <= quo[g] | (QB'(hit) << BIT);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[g+1] <= 1'b0;
      end else begin
        dv[g+1] <= dv[g];
      end
    end
  end

  // saturate and register the result
  always_ff @(posedge clk) begin
    result <= quo[QB][QB-1] ? 16'hFFFF : quo[QB][15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= dv[QB];
    end
  end

endmodule

@@ verif/tvn_checker.sv @@
// tvn_checker: watches the pixel, result and register channels of the noise block
// predicts each noise level and compares; depends on tvn_pkg
`timescale 1ns / 1ps
module tvn_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [11:0] pixel_x,
  input  logic [11:0] pixel_y,
  input  logic        done,
  input  logic [15:0] noise_level,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          outstanding
);

  logic [3:0]  tile_log2_q;
  logic [6:0]  base_period_q;
  logic [3:0]  octave_count_q;
  logic [31:0] noise_seed_q;
  logic [15:0] level_queue[$];

  function automatic logic [31:0] hash_mix(logic [31:0] a);
    a = a ^ (a >> 16);
    a = a * tvn_pkg::MIX_M1;
    a = a ^ (a >> 15);
    a = a * tvn_pkg::MIX_M2;
    a = a ^ (a >> 16);
    return a;
  endfunction

  function automatic longint lattice_value(longint i, longint j, logic [31:0] seed);
    logic [31:0] h;
    h = i[31:0] * tvn_pkg::HASH_KX + j[31:0] * tvn_pkg::HASH_KY + seed;
    return longint'(hash_mix(h) >> 16);
  endfunction

  // Q0.16 fraction to Q1.16 smoothstep weight, rounded half up
  function automatic longint smooth_weight(longint f);
    longint unsigned p;
    p = f * f * (196608 - 2 * f);
    return longint'((p + 64'h8000_0000) >> 32);
  endfunction

  function automatic longint octave_level(longint px, longint py, longint period,
                                          logic [31:0] seed);
    int     sh;
    longint mask, fx, fy, tx, ty, x0, y0, x1, y1, a, b, c, d, top, bot, v;
    sh   = tile_log2_q;
    mask = (64'd1 << sh) - 1;
    fx   = px * period;
    fy   = py * period;
    tx   = smooth_weight((fx & mask) << (16 - sh));
    ty   = smooth_weight((fy & mask) << (16 - sh));
    x0   = (fx >> sh) % period;
    y0   = (fy >> sh) % period;
    x1   = (x0 + 1) % period;
    y1   = (y0 + 1) % period;
    a    = lattice_value(x0, y0, seed);
    b    = lattice_value(x1, y0, seed);
    c    = lattice_value(x0, y1, seed);
    d    = lattice_value(x1, y1, seed);
    top  = a * 65536 + (b - a) * tx;
    bot  = c * 65536 + (d - c) * tx;
    v    = top * 65536 + (bot - top) * ty;
    if (v < 0) v = 0;
    return (v + 64'h8000_0000) >> 32;
  endfunction

  // weighted octave sum, normalised and rounded half up
  function automatic logic [15:0] noise_of_pixel(logic [11:0] x, logic [11:0] y);
    int          k;
    longint      base, s, den, r;
    logic [31:0] seed;
    k    = octave_count_q;
    base = (base_period_q == 0) ? 1 : base_period_q;
    if (k == 0) k = 1;
    if (k > 8) k = 8;
    s = 0;
    for (int o = 0; o < k; o++) begin
      seed = noise_seed_q + o * tvn_pkg::OCT_STEP;
      s += octave_level(x, y, base << o, seed) << (k - 1 - o);
    end
    den = (64'd1 << k) - 1;
    r   = (2 * s + den) / (2 * den);
    if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  assign outstanding = level_queue.size();

  always @(posedge clk) begin
    if (rst) begin
      tile_log2_q    <= tvn_pkg::TILE_LOG2_RST;
      base_period_q  <= tvn_pkg::BASE_PERIOD_RST;
      octave_count_q <= tvn_pkg::OCTAVE_COUNT_RST;
      noise_seed_q   <= tvn_pkg::NOISE_SEED_RST;
      errors         <= 0;
      level_queue.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (tvn_pkg::reg_index_t'(cfg_index))
          tvn_pkg::REG_TILE_LOG2:    tile_log2_q    <= cfg_data[3:0];
          tvn_pkg::REG_BASE_PERIOD:  base_period_q  <= cfg_data[6:0];
          tvn_pkg::REG_OCTAVE_COUNT: octave_count_q <= cfg_data[3:0];
          tvn_pkg::REG_NOISE_SEED:   noise_seed_q   <= cfg_data;
          default: ;
        endcase
      end
      // result check against the oldest expectation
      if (done) begin
        if (level_queue.size() == 0) begin
          if (errors < 10) $display("unexpected result %0d", noise_level);
          errors <= errors + 1;
        end else begin
          if (level_queue[0] !== noise_level) begin
            if (errors < 10)
              $display("noise mismatch: expected %0d actual %0d", level_queue[0], noise_level);
            errors <= errors + 1;
          end
          void'(level_queue.pop_front());
        end
      end
      // accepted pixel transaction
      if (start && !busy) level_queue.push_back(noise_of_pixel(pixel_x, pixel_y));
    end
  end
endmodule

@@ verif/tileable_value_noise_fbm_test.sv @@
// tileable_value_noise_fbm_test: stimulus and verdict for the tileable noise block
// depends on tvn_pkg, tileable_value_noise_fbm and tvn_checker
`timescale 1ns / 1ps
module tileable_value_noise_fbm_test;

  logic        clk = 0, rst = 1, start = 0, cfg_we = 0;
  logic [11:0] pixel_x = 0, pixel_y = 0;
  logic [1:0]  cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic        busy, done;
  logic [15:0] noise_level;
  int          errors, outstanding, quiet_cycles, pixel_count, result_count;
  bit          idle_on;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  tileable_value_noise_fbm u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel_x(pixel_x),
    .pixel_y(pixel_y), .done(done), .noise_level(noise_level), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tvn_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel_x(pixel_x),
    .pixel_y(pixel_y), .done(done), .noise_level(noise_level), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
    .outstanding(outstanding)
  );

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (!rst && done) result_count <= result_count + 1;
    if (quiet_cycles > 3000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // all four registers in one burst
  task automatic load_registers(logic [3:0] tl, logic [6:0] bp, logic [3:0] oc,
                                logic [31:0] sd);
    cfg_we <= 1; cfg_index <= tvn_pkg::REG_TILE_LOG2;    cfg_data <= {$urandom} & ~32'hf | tl;
    @(posedge clk);
    cfg_index <= tvn_pkg::REG_BASE_PERIOD;  cfg_data <= {$urandom} & ~32'h7f | bp;
    @(posedge clk);
    cfg_index <= tvn_pkg::REG_OCTAVE_COUNT; cfg_data <= {$urandom} & ~32'hf | oc;
    @(posedge clk);
    cfg_index <= tvn_pkg::REG_NOISE_SEED;   cfg_data <= sd;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // one pixel transaction, at times with a random gap ahead of it while idle_on is set
  task automatic send_pixel(logic [11:0] x, logic [11:0] y);
    if (idle_on && $urandom_range(99) < 32) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1; pixel_x <= x; pixel_y <= y;
    @(posedge clk);
    while (busy) @(posedge clk);
    pixel_count++;
  endtask

  task automatic drain;
    start <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic run_phase(logic [3:0] tl, logic [6:0] bp, logic [3:0] oc,
                           logic [31:0] sd, int count);
    logic [11:0] side_mask;
    load_registers(tl, bp, oc, sd);
    side_mask = (tl >= 12) ? 12'hfff : ((12'd1 << tl) - 1);
    // corners of the tile and the far corner of the coordinate range
    send_pixel(0, 0);
    send_pixel(side_mask, side_mask);
    send_pixel(side_mask, 0);
    send_pixel(12'hfff, 12'hfff);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0) send_pixel($urandom, $urandom);
      else send_pixel($urandom & side_mask, $urandom & side_mask);
      // in phases with a tile log2 of 5, one pause mid-phase until all results are back
      if (n == count / 2 && tl == 4'd5) begin
        start <= 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
    end
    drain();
  endtask

  initial begin
    pixel_count = 0; result_count = 0; idle_on = 1;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // reset defaults first, with a short directed raster
    for (int n = 0; n < 8; n++) send_pixel(n * 37, 255 - n * 29);
    drain();
    run_phase(4'd1, 7'd1, 4'd1, 32'd0, 60);
    run_phase(4'd12, 7'd64, 4'd8, 32'hffff_ffff, 120);
    // zero period and zero octaves fall back to one
    run_phase(4'd0, 7'd0, 4'd0, $urandom, 60);
    // out-of-range tile, full period field, saturated octave count
    run_phase(4'd15, 7'd127, 4'd15, $urandom, 100);
    idle_on = 0;
    run_phase(4'd8, 7'd4, 4'd3, 32'd40503, 150);
    idle_on = 1;
    run_phase(4'd5, 7'd3, 4'd5, $urandom, 150);
    for (int p = 0; p < 6; p++)
      run_phase($urandom_range(1, 12), $urandom_range(1, 64), $urandom_range(1, 8),
                $urandom, 120);
    $display("covered %0d pixels over 13 register settings, %0d levels checked",
             pixel_count, result_count);
    $display("settings included zero and saturated counts, tile sizes 2 to 4096 and beyond");
    if (errors == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
